// ----- rtl/core/sfc_pkg.sv -----
// Shared types, command/status structs and constants for the SFLOAT16 converter.
// Used by sfc_ctrl, sfc_dp and sfloat16_double_converter_core; no dependencies.
`default_nettype none
package sfc_pkg;

  // SFLOAT mantissa codes
  localparam logic [11:0] MANT_POS_INF = 12'h7FE;
  localparam logic [11:0] MANT_NAN     = 12'h7FF;
  localparam logic [11:0] MANT_NEG_INF = 12'h802;

  // binary64 patterns
  localparam logic [63:0] BITS_POS_INF = 64'h7FF0000000000000;
  localparam logic [63:0] BITS_NEG_INF = 64'hFFF0000000000000;
  localparam logic [63:0] BITS_QNAN    = 64'h7FF8000000000000;
  localparam logic [63:0] BITS_2046    = 64'h409FF80000000000;
  localparam logic [63:0] BITS_TENTH   = 64'h3FB999999999999A;
  localparam logic [63:0] BITS_TEN     = 64'h4024000000000000;

  // multiplier A operand sources
  localparam logic [1:0] SRC_D    = 2'd0;
  localparam logic [1:0] SRC_2046 = 2'd1;
  localparam logic [1:0] SRC_INT  = 2'd2;

  // multiplier B operand selects
  localparam logic [1:0] B_TENTH = 2'd0;
  localparam logic [1:0] B_TEN   = 2'd1;
  localparam logic [1:0] B_TABLE = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;
    logic       unpk;
    logic [1:0] a_src;
    logic [1:0] b_sel;
    logic       norm;
    logic       pp0;
    logic       pp1;
    logic       rnd;
    logic       dest_lo;
    logic       e_inc;
    logic       e_dec;
    logic       out_load;
  } sfc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_dec;
    logic enc_special;
    logic dec_direct;
    logic a_norm;
    logic ge_hi;
    logic lt_lo;
  } sfc_stat_t;

  // 10^(idx-8) as binary64
  function automatic logic [63:0] pow10_bits(input logic [3:0] idx);
    logic [63:0] r;
    unique case (idx)
      4'd0:  r = 64'h3E45798EE2308C3A;
      4'd1:  r = 64'h3E7AD7F29ABCAF48;
      4'd2:  r = 64'h3EB0C6F7A0B5ED8D;
      4'd3:  r = 64'h3EE4F8B588E368F1;
      4'd4:  r = 64'h3F1A36E2EB1C432D;
      4'd5:  r = 64'h3F50624DD2F1A9FC;
      4'd6:  r = 64'h3F847AE147AE147B;
      4'd7:  r = 64'h3FB999999999999A;
      4'd8:  r = 64'h3FF0000000000000;
      4'd9:  r = 64'h4024000000000000;
      4'd10: r = 64'h4059000000000000;
      4'd11: r = 64'h408F400000000000;
      4'd12: r = 64'h40C3880000000000;
      4'd13: r = 64'h40F86A0000000000;
      4'd14: r = 64'h412E848000000000;
      default: r = 64'h416312D000000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfc_ctrl.sv -----
// Sequencing state machine for the SFLOAT16 converter.
// Depends on sfc_pkg; drives sfc_dp through sfc_cmd_t.
`default_nettype none
module sfc_ctrl
  import sfc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire sfc_stat_t stat,
  output sfc_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_UNPK = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_PP0  = 4'd4;
  localparam logic [3:0] S_PP1  = 4'd5;
  localparam logic [3:0] S_RND  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [1:0] PH_LO   = 2'd0;
  localparam logic [1:0] PH_DOWN = 2'd1;
  localparam logic [1:0] PH_UP   = 2'd2;
  localparam logic [1:0] PH_DEC  = 2'd3;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_dec) begin
          if (stat.dec_direct) begin
            state_next = S_FIN;
          end else begin
            phase_next = PH_DEC;
            state_next = S_UNPK;
          end
        end else if (stat.enc_special) begin
          state_next = S_FIN;
        end else begin
          phase_next = PH_LO;
          state_next = S_UNPK;
        end
      end
      S_UNPK: begin
        cmd.unpk = 1'b1;
        unique case (phase)
          PH_LO:   begin cmd.a_src = SRC_2046; cmd.b_sel = B_TENTH; end
          PH_DOWN: begin cmd.a_src = SRC_D;    cmd.b_sel = B_TENTH; end
          PH_UP:   begin cmd.a_src = SRC_D;    cmd.b_sel = B_TEN;   end
          default: begin cmd.a_src = SRC_INT;  cmd.b_sel = B_TABLE; end
        endcase
        state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.a_norm) begin
          state_next = S_PP0;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_PP0: begin
        cmd.pp0    = 1'b1;
        state_next = S_PP1;
      end
      S_PP1: begin
        cmd.pp1    = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd     = 1'b1;
        cmd.dest_lo = (phase == PH_LO);
        cmd.e_inc   = (phase == PH_DOWN);
        cmd.e_dec   = (phase == PH_UP);
        state_next  = (phase == PH_DEC) ? S_FIN : S_CHK;
      end
      S_CHK: begin
        // scale down first, then up; once scaling up, never back down
        if (stat.ge_hi && (phase != PH_UP)) begin
          phase_next = PH_DOWN;
          state_next = S_UNPK;
        end else if (stat.lt_lo) begin
          phase_next = PH_UP;
          state_next = S_UNPK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LO;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sfc_dp.sv -----
// Datapath: operand registers, multi-cycle binary64 multiplier, SFLOAT pack/unpack.
// Depends on sfc_pkg; controlled by sfc_ctrl through sfc_cmd_t.
`default_nettype none
module sfc_dp
  import sfc_pkg::*;
(
  input  wire logic        clk,
  input  wire sfc_cmd_t    cmd,
  output sfc_stat_t        stat,
  input  wire logic        in_cmd,
  input  wire logic [63:0] in_double_bits,
  input  wire logic [15:0] in_sfloat_word,
  output logic [15:0]      out_sfloat_word,
  output logic [63:0]      out_double_bits,
  output logic             out_of_range
);

  logic               op_dec;
  logic [63:0]        x;
  logic [15:0]        word;
  logic [63:0]        d;
  logic [63:0]        lo;
  logic signed [10:0] e;
  logic [52:0]        ma;
  logic signed [12:0] ea;
  logic               sa;
  logic [52:0]        mb;
  logic [10:0]        eb;
  logic [105:0]       acc;

  // operand unpack
  logic [63:0] a_bits, b_bits;
  logic [11:0] m_int, m_abs;
  always_comb begin
    a_bits = (cmd.a_src == SRC_2046) ? BITS_2046 : d;
    m_int  = word[11:0];
    m_abs  = m_int[11] ? (12'd0 - m_int) : m_int;
    case (cmd.b_sel)
      B_TEN:   b_bits = BITS_TEN;
      B_TABLE: b_bits = pow10_bits(word[15:12] ^ 4'h8);
      default: b_bits = BITS_TENTH;
    endcase
  end

  // rounding stage of the multiplier
  logic               hi;
  logic [105:0]       q, qs;
  logic signed [13:0] er, nsh;
  logic [6:0]         sh;
  logic               lost, g, st;
  logic [52:0]        mant;
  logic [53:0]        mr;
  logic [10:0]        base;
  logic [62:0]        mag;
  logic [63:0]        res;
  always_comb begin
    hi  = acc[105];
    q   = hi ? acc : {acc[104:0], 1'b0};
    er  = {ea[12], ea} + $signed({3'b000, eb}) - 14'sd1022 - (hi ? 14'sd0 : 14'sd1);
    nsh = 14'sd1 - er;
    if (er >= 14'sd1) begin
      sh = 7'd0;
    end else if (nsh > 14'sd106) begin
      sh = 7'd106;
    end else begin
      sh = nsh[6:0];
    end
    qs   = q >> sh;
    lost = ((qs << sh) != q);
    mant = qs[105:53];
    g    = qs[52];
    st   = (|qs[51:0]) | lost;
    mr   = {1'b0, mant} + {53'd0, g & (st | mant[0])};
    base = (er >= 14'sd1) ? 11'(er - 14'sd1) : 11'd0;
    mag  = {base, 52'd0} + {9'd0, mr};
    res  = {sa, mag};
  end

  // final SFLOAT encode from the scaled value
  logic [52:0]        m53;
  logic [5:0]         tsh;
  logic [10:0]        dex;
  logic [52:0]        tq, hq;
  logic [11:0]        t1, t2;
  logic signed [11:0] e2;
  logic               neg;
  logic [15:0]        enc_word;
  logic               enc_flag;
  logic [63:0]        dec_bits;
  always_comb begin
    m53 = {1'b1, d[51:0]};
    dex = 11'd1075 - d[62:52];
    tsh = dex[5:0];
    tq  = m53 >> tsh;
    hq  = m53 >> (tsh - 6'd1);
    t1  = tq[11:0] + {11'd0, hq[0]};
    e2  = {e[10], e};
    t2  = t1;
    if (t1 >= 12'd2046) begin
      t2 = 12'd205;
      e2 = e2 + 12'sd1;
    end
    neg      = x[63];
    enc_flag = 1'b0;
    if (x[62:52] == 11'h7FF) begin
      if (x[51:0] != 52'd0) begin
        enc_word = {4'h0, MANT_NAN};
      end else begin
        enc_word = {4'h0, neg ? MANT_NEG_INF : MANT_POS_INF};
      end
    end else if (x[62:0] == 63'd0) begin
      enc_word = 16'h0000;
    end else if (e2 > 12'sd7) begin
      enc_flag = 1'b1;
      enc_word = {4'h0, neg ? MANT_NEG_INF : MANT_POS_INF};
    end else if (e2 < -12'sd8) begin
      enc_flag = 1'b1;
      enc_word = 16'h0000;
    end else begin
      enc_word = {e2[3:0], neg ? (12'd0 - t2) : t2};
    end

    // decode specials and zero bypass the multiplier
    if (word[11:0] == MANT_POS_INF) begin
      dec_bits = BITS_POS_INF;
    end else if (word[11:0] == MANT_NEG_INF) begin
      dec_bits = BITS_NEG_INF;
    end else if (word[11:0] == MANT_NAN) begin
      dec_bits = BITS_QNAN;
    end else if (word[11:0] == 12'd0) begin
      dec_bits = 64'd0;
    end else begin
      dec_bits = d;
    end
  end

  // status
  always_comb begin
    stat.is_dec      = op_dec;
    stat.enc_special = (x[62:52] == 11'h7FF) || (x[62:0] == 63'd0);
    stat.dec_direct  = (word[11:0] == MANT_POS_INF) || (word[11:0] == MANT_NEG_INF) ||
                       (word[11:0] == MANT_NAN) || (word[11:0] == 12'd0);
    stat.a_norm      = ma[52];
    stat.ge_hi       = (d[62:0] >= BITS_2046[62:0]);
    stat.lt_lo       = (d[62:0] < lo[62:0]);
  end

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_dec <= in_cmd;
      x      <= in_double_bits;
      d      <= in_double_bits;
      word   <= in_sfloat_word;
      e      <= 11'sd0;
    end
    if (cmd.unpk) begin
      if (cmd.a_src == SRC_INT) begin
        ma <= {41'd0, m_abs};
        ea <= 13'sd1075;
        sa <= m_int[11];
      end else begin
        ma <= {(a_bits[62:52] != 11'd0), a_bits[51:0]};
        ea <= (a_bits[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, a_bits[62:52]});
        sa <= a_bits[63];
      end
      mb <= {1'b1, b_bits[51:0]};
      eb <= b_bits[62:52];
    end
    // one left shift per cycle for subnormal or integer operands
    if (cmd.norm) begin
      ma <= {ma[51:0], 1'b0};
      ea <= ea - 13'sd1;
    end
    // two partial products, 53 x 27 and 53 x 26 bits, kept at full width
    if (cmd.pp0) begin
      acc <= {26'd0, 80'(ma) * 80'(mb[26:0])};
    end
    if (cmd.pp1) begin
      acc <= acc + {79'(ma) * 79'(mb[52:27]), 27'd0};
    end
    if (cmd.rnd) begin
      if (cmd.dest_lo) begin
        lo <= res;
      end else begin
        d <= res;
      end
      if (cmd.e_inc) begin
        e <= e + 11'sd1;
      end else if (cmd.e_dec) begin
        e <= e - 11'sd1;
      end
    end
    if (cmd.out_load) begin
      if (op_dec) begin
        out_sfloat_word <= 16'd0;
        out_double_bits <= dec_bits;
        out_of_range    <= 1'b0;
      end else begin
        out_sfloat_word <= enc_word;
        out_double_bits <= 64'd0;
        out_of_range    <= enc_flag;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sfloat16_double_converter_core.sv -----
// Top level of the SFLOAT16 <-> binary64 converter.
// Depends on sfc_pkg, sfc_ctrl and sfc_dp.
// One item is worked at a time. Each binary64 multiply runs unpack, the left shifts
// of a subnormal or integer operand, two partial products (53x27 and 53x26 bits)
// and round; an encode then tests the loop bounds. Decoding a special or zero
// mantissa skips the multiplier; any other decode takes longer the more left shifts
// the integer mantissa needs. Encoding a special value skips the multiplier;
// otherwise the time grows with n scaling steps and the left shifts of subnormal
// operands, n being near |log10| of the input distance from the 204.6..2046
// window. The next item is accepted as soon as the previous result sits in the
// output register, even if it has not been taken.
`default_nettype none
module sfloat16_double_converter_core
  import sfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [63:0] in_double_bits,
  input  wire logic [15:0] in_sfloat_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_sfloat_word,
  output logic [63:0]      out_double_bits,
  output logic             out_of_range
);

  sfc_cmd_t  ctl;
  sfc_stat_t stat;

  sfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (ctl)
  );

  sfc_dp u_dp (
    .clk             (clk),
    .cmd             (ctl),
    .stat            (stat),
    .in_cmd          (cmd),
    .in_double_bits  (in_double_bits),
    .in_sfloat_word  (in_sfloat_word),
    .out_sfloat_word (out_sfloat_word),
    .out_double_bits (out_double_bits),
    .out_of_range    (out_of_range)
  );

`ifndef SYNTHESIS
  // an accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after transfer");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !(out_valid && out_stall))
    else $error("output overwritten while stalled");

  // multiplier steps are exclusive
  a_mul_steps: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.unpk, ctl.norm, ctl.pp0, ctl.pp1, ctl.rnd, ctl.out_load}))
    else $error("overlapping datapath commands");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_sfloat16_double_converter_core.sv -----
// Self-checking testbench for sfloat16_double_converter_core.
// Depends on sfc_pkg and the converter RTL. It predicts each encode and decode
// with real arithmetic and checks results in order, under random bursts and stalls.
`default_nettype none
module tb_sfloat16_double_converter_core;
  import sfc_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct {
    logic        cmd;
    logic [63:0] dbits;
    logic [15:0] word;
  } conv_item_t;

  typedef struct {
    logic [15:0] word;
    logic [63:0] dbits;
    logic        oor;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = 1'b0;
  logic [63:0] in_double_bits = '0;
  logic [15:0] in_sfloat_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_sfloat_word;
  logic [63:0] out_double_bits;
  logic        out_of_range;

  conv_item_t   pending_q[$];
  conv_result_t expected_q[$];
  int           err_count = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_mode = 0;
  int           stall_phase = 0;
  real          pow10_r[16] = '{1e-8, 1e-7, 1e-6, 1e-5, 1e-4, 1e-3, 1e-2, 1e-1,
                                1e0, 1e1, 1e2, 1e3, 1e4, 1e5, 1e6, 1e7};

  sfloat16_double_converter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .in_double_bits(in_double_bits), .in_sfloat_word(in_sfloat_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sfloat_word(out_sfloat_word), .out_double_bits(out_double_bits),
    .out_of_range(out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // binary64 -> SFLOAT word, with scaling by 0.1 / 10.0 and saturation
  function automatic conv_result_t sfloat_encode(input logic [63:0] b);
    conv_result_t r;
    real d, lo, a;
    int e, t, m;
    logic neg;
    r = '{16'h0, 64'h0, 1'b0};
    neg = b[63];
    e = 0;
    if (b[62:0] == '0) return r;
    if (b[62:52] == 11'h7FF) begin
      r.word = (b[51:0] != '0) ? {4'h0, MANT_NAN} : (neg ? {4'h0, MANT_NEG_INF}
                                                        : {4'h0, MANT_POS_INF});
      return r;
    end
    d = $bitstoreal(b);
    lo = 2046.0 * 0.1;
    while ((d < 0.0 ? -d : d) >= 2046.0) begin
      d = d * 0.1;
      e++;
    end
    while ((d < 0.0 ? -d : d) < lo) begin
      d = d * 10.0;
      e--;
    end
    a = d < 0.0 ? -d : d;
    t = $rtoi(a);
    if (a - t >= 0.5) t++;
    // rounding up to 2046 would collide with the infinity code
    if (t >= 2046) begin
      t = 205;
      e++;
    end
    if (e > 7) begin
      r.oor = 1'b1;
      r.word = neg ? {4'h0, MANT_NEG_INF} : {4'h0, MANT_POS_INF};
    end else if (e < -8) begin
      r.oor = 1'b1;
    end else begin
      m = neg ? -t : t;
      r.word = {e[3:0], m[11:0]};
    end
    return r;
  endfunction

  // SFLOAT word -> binary64
  function automatic conv_result_t sfloat_decode(input logic [15:0] w);
    conv_result_t r;
    int m, e;
    r = '{16'h0, 64'h0, 1'b0};
    if (w[11:0] == MANT_POS_INF) r.dbits = BITS_POS_INF;
    else if (w[11:0] == MANT_NEG_INF) r.dbits = BITS_NEG_INF;
    else if (w[11:0] == MANT_NAN) r.dbits = BITS_QNAN;
    else begin
      m = $signed(w[11:0]);
      e = $signed(w[15:12]);
      r.dbits = $realtobits(m * pow10_r[e + 8]);
    end
    return r;
  endfunction

  task automatic add_item(input logic c, input logic [63:0] db, input logic [15:0] w);
    conv_item_t it;
    it.cmd = c;
    it.dbits = db;
    it.word = w;
    pending_q.push_back(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_q.push_back(cmd == CMD_ENC ? sfloat_encode(in_double_bits)
                                            : sfloat_decode(in_sfloat_word));
        void'(pending_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid <= 1'b1;
        cmd <= pending_q[0].cmd;
        in_double_bits <= pending_q[0].dbits;
        in_sfloat_word <= pending_q[0].word;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: free-running, light or heavy stalling by phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_phase <= $urandom_range(50, 400);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 9) < 3);
        end
        default: begin
          out_stall <= ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    conv_result_t x;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no pending expectation");
        err_count++;
      end else begin
        x = expected_q.pop_front();
        if (out_sfloat_word !== x.word) begin
          $error("out_sfloat_word expected %h got %h", x.word, out_sfloat_word);
          err_count++;
        end
        if (out_double_bits !== x.dbits) begin
          $error("out_double_bits expected %h got %h", x.dbits, out_double_bits);
          err_count++;
        end
        if (out_of_range !== x.oor) begin
          $error("out_of_range expected %b got %b", x.oor, out_of_range);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] db;
    int k;
    // directed encodes: zeros, NaN, infinities, window edges, saturation
    add_item(CMD_ENC, 64'h0000000000000000, 16'hFFFF);
    add_item(CMD_ENC, 64'h8000000000000000, 16'h0000);
    add_item(CMD_ENC, 64'h7FF0000000000001, 16'h0);
    add_item(CMD_ENC, 64'hFFFFFFFFFFFFFFFF, 16'h0);
    add_item(CMD_ENC, BITS_POS_INF, 16'h0);
    add_item(CMD_ENC, BITS_NEG_INF, 16'h0);
    add_item(CMD_ENC, $realtobits(2045.7), 16'h0);
    add_item(CMD_ENC, $realtobits(-2045.5), 16'h0);
    add_item(CMD_ENC, $realtobits(204.6), 16'h0);
    add_item(CMD_ENC, $realtobits(-2046.0), 16'h0);
    add_item(CMD_ENC, $realtobits(3.14159), 16'h0);
    add_item(CMD_ENC, $realtobits(1.0e10), 16'h0);
    add_item(CMD_ENC, $realtobits(-1.0e10), 16'h0);
    add_item(CMD_ENC, $realtobits(1.0e-12), 16'h0);
    add_item(CMD_ENC, 64'h7FEFFFFFFFFFFFFF, 16'h0);
    add_item(CMD_ENC, 64'h0000000000000001, 16'h0);
    // directed decodes: specials with any exponent, most negative, extremes
    add_item(CMD_DEC, 64'hFFFFFFFFFFFFFFFF, 16'h57FE);
    add_item(CMD_DEC, 64'h0, 16'hA802);
    add_item(CMD_DEC, 64'h0, 16'hF7FF);
    add_item(CMD_DEC, 64'h0, 16'h0800);
    add_item(CMD_DEC, 64'h0, 16'h7801);
    add_item(CMD_DEC, 64'h0, 16'h77FD);
    add_item(CMD_DEC, 64'h0, 16'h8001);
    add_item(CMD_DEC, 64'h0, 16'h8000);
    add_item(CMD_DEC, 64'h0, 16'hFFFF);
    // random: mostly moderate exponents, some fully random patterns
    for (k = 0; k < 900; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        db = rand64();
        if ($urandom_range(0, 9) != 0)
          db[62:52] = 11'(32'd983 + $urandom_range(0, 80));
        add_item(CMD_ENC, db, 16'($urandom_range(0, 65535)));
      end else begin
        add_item(CMD_DEC, rand64(), 16'($urandom_range(0, 65535)));
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sfloat16_double_converter_core.f -----
rtl/core/sfc_pkg.sv
rtl/core/sfc_ctrl.sv
rtl/core/sfc_dp.sv
rtl/core/sfloat16_double_converter_core.sv
tb/tb_sfloat16_double_converter_core.sv
